FILE: rtl/swt_pkg.sv
// types, constants and character codes shared by the shell word tokenizer
`default_nettype none

package swt_pkg;

   // longest token is MAX_TOKEN-1 bytes
   localparam int unsigned MAX_TOKEN = 1024;
   localparam int unsigned LEN_W     = (MAX_TOKEN > 2) ? $clog2(MAX_TOKEN) : 1;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN - 1);

   // request kinds
   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // characters of interest
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;

   // result queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QUEUE_ROOM = QCNT_W'(QUEUE_DEPTH - 2);

   typedef struct packed {
      logic       has_byte;
      logic [7:0] token_byte;
      logic       token_end;
      logic       truncated;
      logic       open_quote;
   } swt_result_type;

   // up to two results from one request
   typedef struct packed {
      logic [1:0]     count;
      swt_result_type r0;
      swt_result_type r1;
   } swt_emit_type;

endpackage

`default_nettype wire

FILE: rtl/shell_word_tokenizer_core.sv
// top level of the shell word tokenizer: byte stream in, token bytes out
//
//  channel  dir  group         transfers
//  -------  ---  ------------  ---------------------------------------------
//  req      in   req_t*        one command-line byte, or a flush
//  rsp      out  rsp_t*        one token byte and/or a token-end mark
//
//  one request per cycle while the queue has room; each request yields zero, one or two results
//  state decision is a single combinational pass on the lexer registers
//  results go to a four-entry queue; a request is taken while it has two free
//  slots, so a byte still goes in while an earlier result waits for rsp_tready
//  a request giving two results is handed out as two transfers at the rsp side
//  reset is synchronous and clears quote modes, length, held operator, queue
`default_nettype none

module shell_word_tokenizer_core
   import swt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tuser,   // [0] op (0 char, 1 flush)

   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] token_byte, [8] truncated,
                                         // [9] open_quote, [15:10] zero
   output logic             rsp_tuser,   // [0] has_byte
   output logic             rsp_tlast    // token_end
);

   logic           req_fire;
   logic           room;
   swt_emit_type   emit;
   swt_result_type head;

   // a request transfer advances the lexer and pushes its results
   assign req_tready = room;
   assign req_fire   = req_tvalid && req_tready;

   swt_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_op   (req_tuser),
      .req_byte (req_tdata),
      .emit     (emit)
   );

   swt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .emit      (emit),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   // result packing
   assign rsp_tdata = {6'b0, head.open_quote, head.truncated, head.token_byte};
   assign rsp_tuser = head.has_byte;
   assign rsp_tlast = head.token_end;

endmodule

`default_nettype wire

FILE: rtl/swt_lexer.sv
// lexer state registers and the per-byte token decision
`default_nettype none

module swt_lexer
   import swt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_fire,
   input  wire logic         req_op,
   input  wire logic [7:0]   req_byte,
   output swt_emit_type      emit
);

   logic             single_q_ff, single_q_in;
   logic             double_q_ff, double_q_in;
   logic [LEN_W-1:0] length_ff,   length_in;
   logic             held_ff,     held_in;
   logic [7:0]       held_op_ff,  held_op_in;
   logic             dropped_ff,  dropped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_q_ff <= 1'b0;
         double_q_ff <= 1'b0;
         length_ff   <= '0;
         held_ff     <= 1'b0;
         held_op_ff  <= '0;
         dropped_ff  <= 1'b0;
      end else if (req_fire) begin
         single_q_ff <= single_q_in;
         double_q_ff <= double_q_in;
         length_ff   <= length_in;
         held_ff     <= held_in;
         held_op_ff  <= held_op_in;
         dropped_ff  <= dropped_in;
      end
   end

   always_comb begin
      swt_result_type res [2];
      logic [1:0] k;
      logic       is_pair;
      logic       do_add;
      logic       do_end;
      logic       do_sep;
      logic       do_hold;
      logic       holdable;

      res[0]      = '0;
      res[1]      = '0;
      k           = 2'd0;
      is_pair     = 1'b0;
      do_add      = 1'b0;
      do_end      = 1'b0;
      do_sep      = 1'b0;
      do_hold     = 1'b0;
      single_q_in = single_q_ff;
      double_q_in = double_q_ff;
      length_in   = length_ff;
      held_in     = held_ff;
      held_op_in  = held_op_ff;
      dropped_in  = dropped_ff;
      holdable    = (req_byte == CH_LT) || (req_byte == CH_GT) ||
                    (req_byte == CH_AMP) || (req_byte == CH_PIPE);

      if (req_op == OP_FLUSH) begin
         if (held_ff) begin
            res[0]     = '{1'b1, held_op_ff, 1'b1, 1'b0, 1'b0};
            k          = 2'd1;
            held_in    = 1'b0;
            held_op_in = '0;
         end else if ((length_ff != '0) || dropped_ff) begin
            res[0] = '{1'b0, 8'h00, 1'b1, dropped_ff, single_q_ff | double_q_ff};
            k      = 2'd1;
         end
         single_q_in = 1'b0;
         double_q_in = 1'b0;
         length_in   = '0;
         dropped_in  = 1'b0;
      end else begin
         if (held_ff) begin
            is_pair = ((held_op_ff == CH_LT) &&
                       ((req_byte == CH_LT) || (req_byte == CH_GT))) ||
                      ((held_op_ff == CH_GT) && (req_byte == CH_GT)) ||
                      ((held_op_ff == CH_AMP) && (req_byte == CH_AMP)) ||
                      ((held_op_ff == CH_PIPE) && (req_byte == CH_PIPE));
            held_in    = 1'b0;
            held_op_in = '0;
            if (is_pair) begin
               res[0] = '{1'b1, held_op_ff, 1'b0, 1'b0, 1'b0};
               res[1] = '{1'b1, req_byte, 1'b1, 1'b0, 1'b0};
               k      = 2'd2;
            end else begin
               res[0] = '{1'b1, held_op_ff, 1'b1, 1'b0, 1'b0};
               k      = 2'd1;
            end
         end

         if (!is_pair) begin
            // classify the byte
            if (single_q_ff) begin
               if (req_byte == CH_SQUOTE) begin
                  single_q_in = 1'b0;
               end
               do_add = 1'b1;
            end else if (double_q_ff) begin
               if (req_byte == CH_DQUOTE) begin
                  double_q_in = 1'b0;
               end
               do_add = 1'b1;
            end else if (req_byte == CH_SQUOTE) begin
               single_q_in = 1'b1;
               do_add      = 1'b1;
            end else if (req_byte == CH_DQUOTE) begin
               double_q_in = 1'b1;
               do_add      = 1'b1;
            end else if ((req_byte == CH_SPACE) || (req_byte == CH_TAB)) begin
               do_end = (length_ff != '0);
            end else if (holdable) begin
               do_end  = (length_ff != '0);
               do_hold = 1'b1;
            end else if ((req_byte == CH_NL) || (req_byte == CH_LPAREN) ||
                         (req_byte == CH_RPAREN)) begin
               do_end = (length_ff != '0);
               do_sep = 1'b1;
            end else begin
               do_add = 1'b1;
            end

            // word ended by a separator
            if (do_end) begin
               res[k[0]]  = '{1'b0, 8'h00, 1'b1, dropped_ff, 1'b0};
               k          = k + 2'd1;
               length_in  = '0;
               dropped_in = 1'b0;
            end

            if (do_add) begin
               if (length_ff < LEN_LIMIT) begin
                  res[k[0]] = '{1'b1, req_byte, 1'b0, 1'b0, 1'b0};
                  k         = k + 2'd1;
                  length_in = length_ff + LEN_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end

            if (do_sep) begin
               res[k[0]] = '{1'b1, req_byte, 1'b1, 1'b0, 1'b0};
               k         = k + 2'd1;
            end

            if (do_hold) begin
               held_in    = 1'b1;
               held_op_in = req_byte;
            end
         end
      end

      emit.count = k;
      emit.r0    = res[0];
      emit.r1    = res[1];
   end

endmodule

`default_nettype wire

FILE: rtl/swt_rsp_queue.sv
// small result queue: takes up to two results a cycle, hands out one
`default_nettype none

module swt_rsp_queue
   import swt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire swt_emit_type emit,
   output logic          room,
   output logic          out_valid,
   input  wire logic     out_ready,
   output swt_result_type out_data
);

   swt_result_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic [1:0]          n_push;
   logic                pop;

   assign n_push    = push ? emit.count : 2'd0;
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign room      = (count_ff <= QUEUE_ROOM);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(n_push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         slot_ff[wr_ptr_ff] <= emit.r0;
      end
      if (n_push == 2'd2) begin
         slot_ff[wr_ptr_ff + QPTR_W'(1)] <= emit.r1;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swt_checker.sv
// port-level checks for the shell word tokenizer, bound to the top level
`default_nettype none

module swt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // no result right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a result without a byte is always a token end
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("byteless result without token end");

   // truncation and open-quote flags ride only on byteless token ends
   a_flags_on_word_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[9:8] == 2'b00))
      else $error("flag set on a byte transfer");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:10] == 6'b0))
      else $error("padding bits set");

endmodule

bind shell_word_tokenizer_core swt_checker u_swt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
